### rtl/core/rwnb_pkg.sv
// rwnb_pkg: shared types and constants of the nearest-beacon picker
// word layouts of both channels, the internal command, reset positions
// no dependencies
`default_nettype none

package rwnb_pkg;

  localparam int IDX_W    = 2;   // beacon index width
  localparam int DBM_W    = 8;   // signal strength width
  localparam int AVG_W    = 8;   // average width
  localparam int POS_W    = 10;  // position width, decimetres
  localparam int IDX_SPAN = 4;   // beacons an index can name, each with a position pair
  localparam int NUM_REGS = 2 * IDX_SPAN;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;   // 4*NUM_REGS bytes

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic [POS_W-1:0] RESET_X [IDX_SPAN] = '{10'd13, 10'd112, 10'd113, 10'd56};
  localparam logic [POS_W-1:0] RESET_Y [IDX_SPAN] = '{10'd90, 10'd69, 10'd27, 10'd16};

  typedef struct packed {
    logic [IDX_W-1:0]        beacon_index;
    logic signed [DBM_W-1:0] signal_dbm;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        nearest_index;
    logic signed [AVG_W-1:0] nearest_average;
    logic [POS_W-1:0]        position_x;
    logic [POS_W-1:0]        position_y;
    logic                    found;
  } out_word_t;

  // classified report handed from front to back
  typedef struct packed {
    logic                    ok;     // index names a tracked beacon
    logic [IDX_W-1:0]        index;
    logic signed [DBM_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/rwnb_front.sv
// rwnb_front: input register stage, classifies each report
// uses rwnb_pkg (in_word_t, cmd_t); feeds rwnb_fifo
`default_nettype none

module rwnb_front #(
  parameter int NB = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  rwnb_pkg::in_word_t  in_word_i,
  output logic                in_stall_o,
  input  wire                 full_i,
  output logic                push_o,
  output rwnb_pkg::cmd_t      cmd_o
);

  logic           hold_q, hold_d;
  rwnb_pkg::cmd_t cmd_q;
  logic           accept;

  assign in_stall_o = hold_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = hold_q && !full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.ok    <= int'(in_word_i.beacon_index) < NB;
      cmd_q.index <= in_word_i.beacon_index;
      cmd_q.value <= in_word_i.signal_dbm;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rwnb_fifo.sv
// rwnb_fifo: short command queue between front and back
// uses rwnb_pkg (cmd_t)
`default_nettype none

module rwnb_fifo #(
  parameter int DEPTH = 2
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  rwnb_pkg::cmd_t  data_i,
  input  wire             pop_i,
  output rwnb_pkg::cmd_t  data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rwnb_pkg::cmd_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q == CNT_W'(DEPTH);
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rwnb_div.sv
// rwnb_div: signed sum by unsigned count, truncated toward zero
// restoring division, four quotient bits a cycle; uses rwnb_pkg (AVG_W)
`default_nettype none

module rwnb_div #(
  parameter int SUM_W = 11,
  parameter int CNT_W = 3
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire signed [SUM_W-1:0]              dividend_i,
  input  wire        [CNT_W-1:0]              divisor_i,
  output logic                                done_o,
  output logic signed [rwnb_pkg::AVG_W-1:0]   quotient_o
);

  localparam int QB    = rwnb_pkg::AVG_W;  // quotient magnitude never exceeds 128
  localparam int BPC   = 4;
  localparam int NCYC  = QB / BPC;
  localparam int CYC_W = (NCYC > 1) ? $clog2(NCYC) : 1;
  localparam int EXT_W = SUM_W + CNT_W;

  logic             busy_q, done_q, neg_q;
  logic [CYC_W-1:0] cyc_q;
  logic [EXT_W-1:0] rem_q, dvs_q;
  logic [QB-1:0]    q_q;
  logic signed [QB-1:0] quot_q;

  logic [SUM_W-1:0] mag;
  logic [EXT_W-1:0] rem_n, dvs_n;
  logic [QB-1:0]    q_n;

  assign mag = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  always_comb begin
    rem_n = rem_q;
    dvs_n = dvs_q;
    q_n   = q_q;
    for (int k = 0; k < BPC; k++) begin
      if (rem_n >= dvs_n) begin
        rem_n = rem_n - dvs_n;
        q_n   = {q_n[QB-2:0], 1'b1};
      end else begin
        q_n   = {q_n[QB-2:0], 1'b0};
      end
      dvs_n = dvs_n >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cyc_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cyc_q == CYC_W'(NCYC - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cyc_q  <= '0;
      end else if (busy_q) begin
        if (cyc_q == CYC_W'(NCYC - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cyc_q <= cyc_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= EXT_W'(mag);
      dvs_q <= EXT_W'(divisor_i) << (QB - 1);
      q_q   <= '0;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      rem_q  <= rem_n;
      dvs_q  <= dvs_n;
      q_q    <= q_n;
      quot_q <= neg_q ? $signed(~q_n + 1'b1) : $signed(q_n);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

### rtl/core/rwnb_back.sv
// rwnb_back: window update, average and nearest-beacon search, result register
// uses rwnb_pkg and rwnb_div; pops commands from rwnb_fifo
`default_nettype none

module rwnb_back #(
  parameter int NB     = 4,
  parameter int WINDOW = 5
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             fifo_empty_i,
  input  rwnb_pkg::cmd_t                  fifo_data_i,
  output logic                            fifo_pop_o,
  input  wire  [rwnb_pkg::POS_W-1:0]      pos_x_i [rwnb_pkg::IDX_SPAN],
  input  wire  [rwnb_pkg::POS_W-1:0]      pos_y_i [rwnb_pkg::IDX_SPAN],
  output logic                            out_valid_o,
  output rwnb_pkg::out_word_t             out_word_o,
  input  wire                             out_stall_i
);

  localparam int AVG_W  = rwnb_pkg::AVG_W;
  localparam int BI_W   = $clog2(NB);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = AVG_W + $clog2(WINDOW);
  localparam int DEPTH  = NB * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_UPD, ST_WAIT, ST_SCAN, ST_OUT
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]        cnt_q    [NB];
  logic [SLOT_W-1:0]       oldest_q [NB];
  logic signed [SUM_W-1:0] sum_q    [NB];
  logic signed [AVG_W-1:0] avg_q    [NB];

  logic [rwnb_pkg::IDX_W-1:0] b_q;
  logic signed [AVG_W-1:0]    v_q;
  logic                       div_start_q;
  logic [BI_W-1:0]            scan_q, best_q;
  logic signed [AVG_W-1:0]    best_avg_q;
  logic                       found_q;
  logic                       out_valid_q;
  rwnb_pkg::out_word_t        out_word_q;

  logic [AVG_W-1:0] store_q [DEPTH];
  logic [AVG_W-1:0] rd_q;

  logic [BI_W-1:0]         bi;
  logic                    full_cur;
  logic [CNT_W:0]          slot_sum, slot_wrap;
  logic [SLOT_W-1:0]       slot, slot_next;
  logic [ADDR_W-1:0]       addr;
  logic signed [SUM_W-1:0] v_ext, old_ext, sum_upd;
  logic                    take, out_free, any_reading;
  logic                    div_done;
  logic signed [AVG_W-1:0] div_quot;

  assign bi       = b_q[BI_W-1:0];
  assign full_cur = cnt_q[bi] == CNT_W'(WINDOW);

  // next slot: oldest + count, wrapped once; the oldest slot when the window is full
  assign slot_sum  = (CNT_W+1)'(oldest_q[bi]) + (CNT_W+1)'(cnt_q[bi]);
  assign slot_wrap = (slot_sum >= (CNT_W+1)'(WINDOW)) ? slot_sum - (CNT_W+1)'(WINDOW)
                                                       : slot_sum;
  assign slot      = full_cur ? oldest_q[bi] : SLOT_W'(slot_wrap);
  assign slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
  assign addr      = ADDR_W'(bi) * ADDR_W'(WINDOW) + ADDR_W'(slot);

  assign v_ext   = SUM_W'(v_q);
  assign old_ext = SUM_W'($signed(rd_q));
  assign sum_upd = full_cur ? sum_q[bi] - old_ext + v_ext : sum_q[bi] + v_ext;

  assign take = (cnt_q[scan_q] != '0) && (!found_q || avg_q[scan_q] > best_avg_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fifo_pop_o = (state_q == ST_IDLE) && !fifo_empty_i;

  always_comb begin
    any_reading = 1'b0;
    for (int i = 0; i < NB; i++) begin
      any_reading = any_reading || (cnt_q[i] != '0);
    end
  end

  rwnb_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (sum_q[bi]),
    .divisor_i  (cnt_q[bi]),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    rd_q <= store_q[addr];
    if (state_q == ST_UPD) begin
      store_q[addr] <= v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      found_q     <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        cnt_q[i]    <= '0;
        oldest_q[i] <= '0;
        sum_q[i]    <= '0;
      end
    end else begin
      // divider starts the cycle after the window update
      div_start_q <= (state_q == ST_UPD);
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_empty_i) begin
            b_q     <= fifo_data_i.index;
            v_q     <= fifo_data_i.value;
            found_q <= 1'b0;
            scan_q  <= '0;
            state_q <= fifo_data_i.ok ? ST_RD : ST_SCAN;
          end
        end
        ST_RD: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          sum_q[bi] <= sum_upd;
          if (full_cur) begin
            oldest_q[bi] <= slot_next;
          end else begin
            cnt_q[bi] <= cnt_q[bi] + 1'b1;
          end
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            avg_q[bi] <= div_quot;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take) begin
            found_q    <= 1'b1;
            best_q     <= scan_q;
            best_avg_q <= avg_q[scan_q];
          end
          if (scan_q == BI_W'(NB - 1)) begin
            state_q <= ST_OUT;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (found_q) begin
              out_word_q.nearest_index   <= rwnb_pkg::IDX_W'(best_q);
              out_word_q.nearest_average <= best_avg_q;
              out_word_q.position_x      <= pos_x_i[rwnb_pkg::IDX_W'(best_q)];
              out_word_q.position_y      <= pos_y_i[rwnb_pkg::IDX_W'(best_q)];
              out_word_q.found           <= 1'b1;
            end else begin
              out_word_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // divider answers only while the back end waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_WAIT)
    else $error("divider done outside wait state");

  // an update always leaves the beacon holding a reading
  a_upd_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> cnt_q[bi] != '0)
    else $error("reading count zero after update");

  // a found result names a beacon that holds readings
  a_best_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && found_q |-> (cnt_q[best_q] != '0) && any_reading)
    else $error("chosen beacon holds no reading");

endmodule

`default_nettype wire

### rtl/core/rssi_window_nearest_beacon_top.sv
// rssi_window_nearest_beacon_top: nearest beacon by windowed average signal strength
// uses rwnb_pkg, rwnb_front, rwnb_fifo, rwnb_back; holds the position registers
`default_nettype none

// Each input word is one signal strength report (dBm) for a beacon index. The
// block keeps the last WINDOW readings of each beacon with a count and a
// running sum, recomputes the truncated average of the reported beacon, then
// scans all beacons for the strictly greatest average (lower index wins a tie)
// and returns one result word per report: index, average, the configured
// position and a found flag (all zero when no beacon holds a reading). A report
// for an index at or above NUM_BEACONS is dropped but still yields a result.
// The back end takes one report at a time: a stored report passes pop, window
// read, update, divider wait, the scan of min(NUM_BEACONS, 4) beacons and
// result load, an ignored one only pop, scan and result load; the front stage
// and the queue let further reports be taken while a result waits on stall.
// Position registers sit on the APB-style port at byte address 4*i, x before
// y for each beacon; pready is tied high and reads return the stored value.

module rssi_window_nearest_beacon_top #(
  parameter int NUM_BEACONS = 4,
  parameter int WINDOW      = 5,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // report channel
  input  wire                               in_valid_i,
  input  rwnb_pkg::in_word_t                in_word_i,
  output logic                              in_stall_o,
  // result channel
  output logic                              out_valid_o,
  output rwnb_pkg::out_word_t               out_word_o,
  input  wire                               out_stall_i,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [rwnb_pkg::APB_AW-1:0]       paddr,
  input  wire  [rwnb_pkg::APB_DW-1:0]       pwdata,
  output logic [rwnb_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  // the 2-bit index reaches at most four beacons
  localparam int NB_ACTIVE = (NUM_BEACONS < rwnb_pkg::IDX_SPAN) ? NUM_BEACONS
                                                                : rwnb_pkg::IDX_SPAN;
  localparam int POS_W = rwnb_pkg::POS_W;

  logic [POS_W-1:0] pos_x_q [rwnb_pkg::IDX_SPAN];
  logic [POS_W-1:0] pos_y_q [rwnb_pkg::IDX_SPAN];

  logic [$clog2(rwnb_pkg::NUM_REGS)-1:0] reg_idx;
  logic [rwnb_pkg::IDX_W-1:0]            reg_beacon;
  logic                                  reg_axis;
  logic                                  cfg_wr;
  logic [POS_W-1:0]                      rd_val;

  // queue hookup
  logic           push, full, empty, pop;
  rwnb_pkg::cmd_t push_cmd, pop_cmd;

  // register decode: word address, beacon in the upper bits, axis in the lsb
  assign reg_idx    = paddr[rwnb_pkg::APB_AW-1:2];
  assign reg_beacon = reg_idx[$clog2(rwnb_pkg::NUM_REGS)-1:1];
  assign reg_axis   = reg_idx[0];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  assign rd_val = (reg_axis == rwnb_pkg::AXIS_Y) ? pos_y_q[reg_beacon]
                                                 : pos_x_q[reg_beacon];
  assign prdata = {{(rwnb_pkg::APB_DW - POS_W){1'b0}}, rd_val};

  // writes for beacons the block does not track are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rwnb_pkg::IDX_SPAN; i++) begin
        pos_x_q[i] <= rwnb_pkg::RESET_X[i];
        pos_y_q[i] <= rwnb_pkg::RESET_Y[i];
      end
    end else if (cfg_wr && (int'(reg_beacon) < NUM_BEACONS)) begin
      if (reg_axis == rwnb_pkg::AXIS_X) begin
        pos_x_q[reg_beacon] <= pwdata[POS_W-1:0];
      end else begin
        pos_y_q[reg_beacon] <= pwdata[POS_W-1:0];
      end
    end
  end

  // front: register the report, flag indexes out of range
  rwnb_front #(
    .NB (NB_ACTIVE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // queue: decouples report intake from the update and search
  rwnb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: window store, divider, scan and result register
  rwnb_back #(
    .NB     (NB_ACTIVE),
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (empty),
    .fifo_data_i  (pop_cmd),
    .fifo_pop_o   (pop),
    .pos_x_i      (pos_x_q),
    .pos_y_i      (pos_y_q),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

`default_nettype wire

### verif/tb_rssi_window_nearest_beacon_top.sv
// tb_rssi_window_nearest_beacon_top: self-checking bench for the nearest-beacon picker
// drives reports, position registers; checks every result word against tracker or table
// depends on rwnb_pkg and rssi_window_nearest_beacon_top

module tb_rssi_window_nearest_beacon_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rwnb_pkg::*;

  localparam int NB             = 4;
  localparam int WIN            = 5;
  localparam int REG_STRIDE     = 4;     // byte distance between position registers
  localparam int SETTLE         = 16;    // pause after a drain before the next phase
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int NDIR           = 23;

  typedef enum int {POS_ZERO, POS_FULL, POS_RANDOM} pos_mode_e;

  // one directed step: report word, whether the result is typed in, the result
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_word_t            in_word_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_word_t           out_word_o;
  logic                out_stall_i = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // local copy of the block's state
  int                  dbm_win [NB][WIN];
  int                  dbm_cnt [NB];
  int                  dbm_old [NB];
  int                  dbm_sum [NB];
  logic [POS_W-1:0]    pos_x [NB];
  logic [POS_W-1:0]    pos_y [NB];

  out_word_t           nearest_q [$];    // results still owed by the block

  int                  errors     = 0;
  int                  n_sent     = 0;
  int                  n_checked  = 0;
  int                  n_settings = 0;
  int                  n_wraps    = 0;
  int                  n_holds    = 0;
  int                  quiet_run  = 0;
  int                  hold_asks  = 0;
  int                  hold_seen  = 0;
  int                  hold_left  = 0;
  logic                no_idle    = 1'b0;
  int                  level [NB];       // per-beacon strength the random reports hover at
  int                  tie_dbm    = 0;

  // directed steps: extremes, ties, truncation toward zero, window wrap on three beacons
  row_t dir_tab [NDIR] = '{
    {2'd0, 8'h80, 1'b1, 2'd0, 8'h80, 10'd13, 10'd90, 1'b1},
    {2'd3, 8'h00, 1'b1, 2'd3, 8'h00, 10'd56, 10'd16, 1'b1},
    {2'd1, 8'h7F, 1'b1, 2'd1, 8'h7F, 10'd112, 10'd69, 1'b1},
    {2'd2, 8'h7F, 1'b1, 2'd1, 8'h7F, 10'd112, 10'd69, 1'b1},  // tie, lower index
    {2'd1, 8'h80, 1'b0, 31'd0},
    {2'd2, 8'h80, 1'b0, 31'd0},
    {2'd2, 8'hFD, 1'b0, 31'd0},
    {2'd0, 8'hFF, 1'b0, 31'd0},
    {2'd0, 8'hFE, 1'b0, 31'd0},
    {2'd0, 8'hF9, 1'b0, 31'd0},
    {2'd0, 8'h80, 1'b0, 31'd0},
    {2'd0, 8'h7F, 1'b0, 31'd0},
    {2'd0, 8'h01, 1'b0, 31'd0},
    {2'd3, 8'hFF, 1'b0, 31'd0},
    {2'd3, 8'hFE, 1'b0, 31'd0},
    {2'd3, 8'h55, 1'b0, 31'd0},
    {2'd3, 8'hAA, 1'b0, 31'd0},
    {2'd3, 8'h80, 1'b0, 31'd0},
    {2'd1, 8'hFB, 1'b0, 31'd0},
    {2'd1, 8'hFB, 1'b0, 31'd0},
    {2'd1, 8'h00, 1'b0, 31'd0},
    {2'd1, 8'h00, 1'b0, 31'd0},
    {2'd2, 8'h01, 1'b0, 31'd0}
  };

  rssi_window_nearest_beacon_top #(
    .NUM_BEACONS (NB),
    .WINDOW      (WIN)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    for (int b = 0; b < NB; b++) begin
      dbm_cnt[b] = 0;
      dbm_old[b] = 0;
      dbm_sum[b] = 0;
      pos_x[b]   = RESET_X[b];
      pos_y[b]   = RESET_Y[b];
      level[b]   = -64;
      for (int s = 0; s < WIN; s++) dbm_win[b][s] = 0;
    end
  end

  // store one report, then pick the beacon with the strictly greatest average
  function automatic out_word_t pick_nearest(input in_word_t w);
    out_word_t res;
    int        b, v, slot, avg, best, best_b;
    logic      any;
    res    = '0;
    best   = -1000;
    best_b = 0;
    any    = 1'b0;
    b      = w.beacon_index;
    v      = w.signal_dbm;
    if (b < NB) begin
      if (dbm_cnt[b] < WIN) begin
        slot = (dbm_old[b] + dbm_cnt[b]) % WIN;
        dbm_cnt[b]++;
      end else begin
        // full window: the oldest reading leaves the sum
        slot = dbm_old[b];
        dbm_sum[b] -= dbm_win[b][slot];
        dbm_old[b] = (slot + 1) % WIN;
        n_wraps++;
      end
      dbm_win[b][slot] = v;
      dbm_sum[b] += v;
    end
    for (int i = 0; i < NB; i++) begin
      if (dbm_cnt[i] != 0) begin
        avg = dbm_sum[i] / dbm_cnt[i];  // int division truncates toward zero
        if (avg > best) begin
          best   = avg;
          best_b = i;
          any    = 1'b1;
        end
      end
    end
    if (any) begin
      res.nearest_index   = best_b[IDX_W-1:0];
      res.nearest_average = best[AVG_W-1:0];
      res.position_x      = pos_x[best_b];
      res.position_y      = pos_y[best_b];
      res.found           = 1'b1;
    end
    return res;
  endfunction

  task automatic report_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // mostly reports near a per-beacon level, the rest full range, edges and exact ties
  function automatic in_word_t rand_report();
    in_word_t w;
    int       r, v;
    r = $urandom_range(99);
    w.beacon_index = IDX_W'($urandom_range(NB - 1));
    if (r < 60) begin
      v = level[w.beacon_index] + int'($urandom_range(6)) - 3;
      if (v < -128) v = -128;
      if (v > 0) v = 0;
    end else if (r < 75) begin
      v = $urandom_range(255);
    end else if (r < 90) begin
      case ($urandom_range(5))
        0: v = -128;
        1: v = -127;
        2: v = -1;
        3: v = 0;
        4: v = 1;
        default: v = 127;
      endcase
    end else begin
      v = tie_dbm;
    end
    w.signal_dbm = v[DBM_W-1:0];
    return w;
  endfunction

  // offer one report word, holding it until taken
  task automatic send_report(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t pred;
    int        gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 15) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = pick_nearest(w);
    nearest_q.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  // sender pause: wait until every owed result word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (nearest_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic run_random(input int count);
    for (int b = 0; b < NB; b++) level[b] = -int'($urandom_range(128));
    tie_dbm = -int'($urandom_range(128));
    for (int k = 0; k < count; k++) send_report(rand_report(), 1'b0, '0);
  endtask

  // setup and access phase, bus left selected so transfers can run back to back
  task automatic write_reg(input int idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * REG_STRIDE);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx[0] == AXIS_X) pos_x[idx / 2] = val[POS_W-1:0];
    else pos_y[idx / 2] = val[POS_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic read_reg(input int idx);
    logic [POS_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(idx * REG_STRIDE);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    want = (idx[0] == AXIS_X) ? pos_x[idx / 2] : pos_y[idx / 2];
    report_field("prdata", {22'd0, want}, prdata);
    @(negedge clk_i);
  endtask

  // write every position register (unless only reading back), then read all back
  task automatic program_positions(input pos_mode_e mode, input logic do_write);
    logic [APB_DW-1:0] val;
    if (do_write) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (mode)
          POS_ZERO: val = '0;
          POS_FULL: val = 32'h0000_03FF;
          default:  val = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1023);
        endcase
        write_reg(i, val);
      end
      n_settings++;
    end
    for (int i = 0; i < NUM_REGS; i++) read_reg(i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // result side: random stall, quiet stretches, and the long hold-off on request
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      n_holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < 15);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    out_word_t want;
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)
        || (psel && penable)) begin
      quiet_run = 0;
    end else begin
      quiet_run++;
    end
    if (quiet_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (nearest_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, actual %h", $time, out_word_o);
      end else begin
        want = nearest_q.pop_front();
        n_checked++;
        report_field("nearest_index", want.nearest_index, out_word_o.nearest_index);
        report_field("nearest_average", want.nearest_average, out_word_o.nearest_average);
        report_field("position_x", want.position_x, out_word_o.position_x);
        report_field("position_y", want.position_y, out_word_o.position_y);
        report_field("found", want.found, out_word_o.found);
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values of the position registers, then the directed steps
    program_positions(POS_RANDOM, 1'b0);
    for (int k = 0; k < NDIR; k++) send_report(dir_tab[k].word, dir_tab[k].typed, dir_tab[k].want);
    drain();

    // all positions at zero, receiver holds off while reports keep coming
    program_positions(POS_ZERO, 1'b1);
    hold_asks++;
    run_random(200);
    drain();

    // all positions at the top, sender pauses halfway until everything is back
    program_positions(POS_FULL, 1'b1);
    run_random(100);
    drain();
    run_random(100);
    drain();

    // stretch with no idling on either side
    program_positions(POS_RANDOM, 1'b1);
    no_idle = 1'b1;
    run_random(300);
    drain();
    no_idle = 1'b0;

    for (int p = 0; p < 4; p++) begin
      program_positions(POS_RANDOM, 1'b1);
      if (p == 2) hold_asks++;
      run_random(232);
      drain();
    end

    $display("%0d reports sent, %0d results checked, %0d position settings",
             n_sent, n_checked, n_settings);
    $display("%0d full-window replacements, %0d long receiver hold-offs", n_wraps, n_holds);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, nearest_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
